/* sv/chte_pkg.sv */
package chte_pkg;

  localparam int Buckets  = 256;
  localparam int Capacity = 1024;
  localparam int BktW     = $clog2(Buckets);
  localparam int NodeW    = $clog2(Capacity);
  localparam int PtrW     = NodeW + 1;
  localparam int HashTop  = 30;
  localparam int HashSh   = (BktW <= HashTop) ? (HashTop - BktW) : 0;
  localparam logic [31:0] HashMult = 32'd1103515249;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpStart  = 2'd2;
  localparam logic [1:0] OpNext   = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StExists  = 3'd1;
  localparam logic [2:0] StMissing = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StWalkEnd = 3'd4;

endpackage

/* sv/chained_hash_table_engine.sv */
// Channel | direction | signals
// command | in        | start_i, busy_o, operation_i, key_i, item_value_i
// result  | out       | done_o, status_o, found_key_o, found_value_o
// Insert/lookup: the result follows the hash and head read plus a read per chain node; a write adds S_WRITE.
// Start/next: the result follows a head read per empty bucket scanned; walk end
// comes after the last bucket scan. Next adds the link read of its node first.
// busy_o drops the cycle after done_o; the next transfer waits for that.
// Reset clears head valid bits, entry count and walk position.
// Results cannot stall.
module chained_hash_table_engine import chte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [31:0] item_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] found_key_o,
  output logic [31:0] found_value_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HRD, S_HWAIT, S_NRD, S_NWAIT, S_WRITE,
    S_WSCAN, S_WSWAIT, S_WNODE, S_WNWAIT, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [31:0] val_q;
  logic [BktW-1:0] bkt_q, bkt_h;
  logic [PtrW-1:0] ptr_q, cnt_q, wnode_q;
  logic [BktW:0]   wbkt_q;
  logic            adv_q;  // next still has to step past the current walk node

  // Memories: heads with valid bits, node pool
  logic [PtrW-1:0] head_mem [Buckets];
  logic [Buckets-1:0] head_vld_q;
  logic [PtrW-1:0] head_rd_q;
  logic            head_rv_q;
  logic [63:0] nkey_mem [Capacity];
  logic [31:0] nval_mem [Capacity];
  logic [PtrW-1:0] nlnk_mem [Capacity];
  logic [63:0] nkey_rd_q;
  logic [31:0] nval_rd_q;
  logic [PtrW-1:0] nlnk_rd_q;

  logic [BktW-1:0] head_ra;
  logic [NodeW-1:0] node_ra;
  logic head_we, node_we;
  logic [PtrW-1:0] head_now;

  chte_hash u_hash (.clk_i, .key_i(key_q), .bucket_o(bkt_h));

  assign head_now = head_rv_q ? head_rd_q : '0;
  assign head_ra  = (state_q == S_WSCAN) ? wbkt_q[BktW-1:0] : bkt_q;
  assign node_ra  = ptr_q[NodeW-1:0] - NodeW'(1);
  assign head_we  = (state_q == S_WRITE);
  assign node_we  = (state_q == S_WRITE);

  // Head memory
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[bkt_q] <= cnt_q + PtrW'(1);
    head_rd_q <= head_mem[head_ra];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      head_rv_q  <= 1'b0;
    end else begin
      head_rv_q <= head_vld_q[head_ra];
      if (head_we) head_vld_q[bkt_q] <= 1'b1;
    end
  end

  // Node memory
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      nkey_mem[cnt_q[NodeW-1:0]] <= key_q;
      nval_mem[cnt_q[NodeW-1:0]] <= val_q;
      nlnk_mem[cnt_q[NodeW-1:0]] <= head_now;
    end
    nkey_rd_q <= nkey_mem[node_ra];
    nval_rd_q <= nval_mem[node_ra];
    nlnk_rd_q <= nlnk_mem[node_ra];
  end

  assign busy_o = (state_q != S_IDLE);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      wbkt_q        <= '0;
      wnode_q       <= '0;
      adv_q         <= 1'b0;
      done_o        <= 1'b0;
      op_q          <= OpInsert;
      ptr_q         <= '0;
      key_q         <= '0;
      val_q         <= '0;
      bkt_q         <= '0;
      status_o      <= StOk;
      found_key_o   <= '0;
      found_value_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          op_q  <= operation_i;
          key_q <= key_i;
          val_q <= item_value_i;
          unique case (operation_i)
            OpStart: begin
              wnode_q <= '0;
              wbkt_q  <= '0;
              state_q <= S_WSCAN;
            end
            OpNext: begin
              if (wnode_q != '0) begin
                ptr_q   <= wnode_q;
                adv_q   <= 1'b1;
                state_q <= S_WNODE;
              end else state_q <= S_WSCAN;
            end
            default: begin
              ptr_q   <= '0;
              state_q <= S_HASH;
            end
          endcase
        end
        S_HASH: state_q <= S_HRD;
        S_HRD: begin
          bkt_q   <= bkt_h;
          state_q <= S_HWAIT;
        end
        S_HWAIT: state_q <= S_NRD;
        S_NRD: begin
          // first pass: take head pointer; later passes: node read issued
          if (ptr_q == '0) begin
            if (head_now == '0) begin
              if (op_q == OpLookup) begin
                status_o <= StMissing; found_key_o <= '0; found_value_o <= '0;
                done_o <= 1'b1; state_q <= S_DONE;
              end else if (cnt_q >= PtrW'(Capacity)) begin
                status_o <= StFull; found_key_o <= '0; found_value_o <= '0;
                done_o <= 1'b1; state_q <= S_DONE;
              end else state_q <= S_WRITE;
            end else begin
              ptr_q <= head_now;
            end
          end else state_q <= S_NWAIT;
        end
        S_NWAIT: begin
          if (nkey_rd_q == key_q) begin
            status_o <= (op_q == OpLookup) ? StOk : StExists;
            found_key_o <= nkey_rd_q; found_value_o <= nval_rd_q;
            done_o <= 1'b1; state_q <= S_DONE;
          end else if (nlnk_rd_q == '0) begin
            if (op_q == OpLookup) begin
              status_o <= StMissing; found_key_o <= '0; found_value_o <= '0;
              done_o <= 1'b1; state_q <= S_DONE;
            end else if (cnt_q >= PtrW'(Capacity)) begin
              status_o <= StFull; found_key_o <= '0; found_value_o <= '0;
              done_o <= 1'b1; state_q <= S_DONE;
            end else begin
              state_q <= S_WRITE;  // head read of this bucket is still current
            end
          end else begin
            ptr_q   <= nlnk_rd_q;
            state_q <= S_NRD;
          end
        end
        S_WRITE: begin
          cnt_q <= cnt_q + PtrW'(1);
          status_o <= StOk; found_key_o <= key_q; found_value_o <= val_q;
          done_o <= 1'b1; state_q <= S_DONE;
        end
        S_WSCAN: begin
          if (wbkt_q >= (BktW+1)'(Buckets)) begin
            status_o <= StWalkEnd; found_key_o <= '0; found_value_o <= '0;
            done_o <= 1'b1; state_q <= S_DONE;
          end else begin
            wbkt_q  <= wbkt_q + (BktW+1)'(1);
            state_q <= S_WSWAIT;
          end
        end
        S_WSWAIT: begin
          if (head_now != '0) begin
            wnode_q <= head_now; ptr_q <= head_now; state_q <= S_WNODE;
          end else state_q <= S_WSCAN;
        end
        S_WNODE: state_q <= S_WNWAIT;  // node read issued
        S_WNWAIT: begin
          if (adv_q) begin
            // step along the link of the current walk node
            adv_q <= 1'b0;
            if (nlnk_rd_q != '0) begin
              wnode_q <= nlnk_rd_q; ptr_q <= nlnk_rd_q; state_q <= S_WNODE;
            end else begin
              wnode_q <= '0; state_q <= S_WSCAN;
            end
          end else begin
            status_o <= StOk; found_key_o <= nkey_rd_q; found_value_o <= nval_rd_q;
            done_o <= 1'b1; state_q <= S_DONE;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/chte_hash.sv */
// Multiplicative bucket hash, one registered stage; low 64 bits of key*mult.
module chte_hash import chte_pkg::*; (
  input  logic            clk_i,
  input  logic [63:0]     key_i,
  output logic [BktW-1:0] bucket_o
);
  logic [63:0] lo_q, hi_q;
  logic [63:0] prod;

  // Two 32x32 partial products, registered before the final add
  always_ff @(posedge clk_i) begin
    lo_q <= {32'd0, key_i[31:0]} * {32'd0, HashMult};
    hi_q <= {32'd0, key_i[63:32]} * {32'd0, HashMult};
  end

  assign prod     = lo_q + {hi_q[31:0], 32'd0};
  assign bucket_o = prod[HashSh +: BktW];
endmodule

/* sv/chte_checker.sv */
module chte_checker import chte_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [63:0] found_key_o,
  input logic [31:0] found_value_o
);
  // Accepted command makes the engine busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  // A result comes only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result while idle");
  // Single-cycle strobe
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe held");
  // Miss, full and walk end carry zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StMissing || status_o == StFull || status_o == StWalkEnd)
    |-> found_key_o == '0 && found_value_o == '0) else $error("payload not zero");
endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (.*);

/* tb/sv/chte_checker.sv */
module chte_scoreboard import chte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [31:0] item_value_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic [63:0] found_key_o,
  input  logic [31:0] found_value_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] fkey;
    logic [31:0] fvalue;
  } answer_t;

  // Shadow table; pointers are node index + 1, zero is null
  logic [PtrW-1:0] head_tbl [Buckets];
  logic [63:0]     key_tbl  [Capacity];
  logic [31:0]     val_tbl  [Capacity];
  logic [PtrW-1:0] link_tbl [Capacity];
  int              used_nodes;
  int              scan_bucket;
  logic [PtrW-1:0] cursor;
  answer_t         answer_q [$];

  assign pending_o = answer_q.size();

  function automatic int bucket_index(logic [63:0] k);
    logic [63:0] h;
    h = k * {32'd0, HashMult};
    return int'((h >> HashSh) & (Buckets - 1));
  endfunction

  function automatic logic [PtrW-1:0] locate(logic [63:0] k);
    logic [PtrW-1:0] p;
    p = head_tbl[BktW'(bucket_index(k))];
    while (p != 0) begin
      if (key_tbl[NodeW'(p - 1)] == k) return p;
      p = link_tbl[NodeW'(p - 1)];
    end
    return '0;
  endfunction

  // Advance past empty buckets, then report the cursor entry
  function automatic answer_t walk_answer();
    answer_t a;
    while (cursor == 0 && scan_bucket < Buckets) begin
      cursor = head_tbl[BktW'(scan_bucket)];
      scan_bucket++;
    end
    if (cursor != 0) a = '{StOk, key_tbl[NodeW'(cursor - 1)], val_tbl[NodeW'(cursor - 1)]};
    else             a = '{StWalkEnd, 64'd0, 32'd0};
    return a;
  endfunction

  function automatic answer_t table_step(logic [1:0] op, logic [63:0] k, logic [31:0] v);
    answer_t         a;
    logic [PtrW-1:0] p;
    int              b;
    case (op)
      OpInsert: begin
        p = locate(k);
        if (p != 0) begin
          a = '{StExists, key_tbl[NodeW'(p - 1)], val_tbl[NodeW'(p - 1)]};
        end else if (used_nodes >= Capacity) begin
          a = '{StFull, 64'd0, 32'd0};
        end else begin
          b = bucket_index(k);
          key_tbl[NodeW'(used_nodes)]  = k;
          val_tbl[NodeW'(used_nodes)]  = v;
          link_tbl[NodeW'(used_nodes)] = head_tbl[BktW'(b)];
          head_tbl[BktW'(b)] = PtrW'(used_nodes + 1);
          used_nodes++;
          a = '{StOk, k, v};
        end
      end
      OpLookup: begin
        p = locate(k);
        if (p != 0) a = '{StOk, key_tbl[NodeW'(p - 1)], val_tbl[NodeW'(p - 1)]};
        else        a = '{StMissing, 64'd0, 32'd0};
      end
      OpStart: begin
        cursor = head_tbl[0];
        scan_bucket = 1;
        a = walk_answer();
      end
      default: begin
        if (cursor != 0) cursor = link_tbl[NodeW'(cursor - 1)];
        a = walk_answer();
      end
    endcase
    return a;
  endfunction

  initial begin
    fail_count_o = 0;
    used_nodes   = 0;
    scan_bucket  = 0;
    cursor       = '0;
    foreach (head_tbl[i]) head_tbl[i] = '0;
  end

  // Compare results, then predict any command transfer of this edge
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d key=%h value=%h",
                   $time, status_o, found_key_o, found_value_o);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            fail_count_o++;
          end
          if (found_key_o !== want.fkey) begin
            $display("%0t: found_key expected %h actual %h", $time, want.fkey, found_key_o);
            fail_count_o++;
          end
          if (found_value_o !== want.fvalue) begin
            $display("%0t: found_value expected %h actual %h",
                     $time, want.fvalue, found_value_o);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_o)
        answer_q.push_back(table_step(operation_i, key_i, item_value_i));
    end
  end

endmodule

/* tb/sv/tb.sv */
module tb import chte_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  operation_i = OpLookup;
  logic [63:0] key_i = '0;
  logic [31:0] item_value_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [63:0] found_key_o;
  logic [31:0] found_value_o;
  int          fail_count;
  int          pending;

  logic [63:0] used_keys [$];
  bit          steady;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  chained_hash_table_engine dut (.*);

  chte_scoreboard u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .key_i, .item_value_i,
    .done_o, .status_o, .found_key_o, .found_value_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Keys are mostly reused so inserts collide and lookups hit
  function automatic logic [63:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(99) < 60)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return rand_key();
  endfunction

  // One command transfer; unless steady, random idle cycles are taken once the engine is ready
  task automatic issue(logic [1:0] op, logic [63:0] k, logic [31:0] v);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < 19) begin
        start_i = 1'b0;
        @(negedge clk_i);
      end
    end
    start_i      = 1'b1;
    operation_i  = op;
    key_i        = k;
    item_value_i = v;
    if (op == OpInsert) used_keys.push_back(k);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic full_walk(int limit);
    issue(OpStart, rand_key(), $urandom());
    repeat (limit) issue(OpNext, rand_key(), $urandom());
  endtask

  initial begin
    int          r;
    logic [1:0]  op;
    logic [63:0] k;
    steady = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extremes, duplicates, walk corners
    issue(OpNext, '0, '0);
    issue(OpStart, '0, '0);
    issue(OpLookup, '0, '0);
    issue(OpInsert, 64'd0, 32'd0);
    issue(OpInsert, '1, '1);
    issue(OpInsert, 64'h0000_0000_FFFF_FFFF, 32'h5555_5555);
    issue(OpInsert, 64'h8000_0000_0000_0000, 32'hAAAA_AAAA);
    issue(OpInsert, '1, 32'h1234_5678);
    issue(OpLookup, '1, '0);
    issue(OpLookup, 64'd0, '0);
    issue(OpLookup, 64'd1, '0);
    issue(OpStart, '0, '0);
    issue(OpNext, '0, '0);
    issue(OpInsert, 64'd12345, 32'd7);
    repeat (5) issue(OpNext, '0, '0);
    issue(OpNext, '0, '0);

    // Random mix; a quiet stretch in the middle runs back to back
    for (int i = 0; i < 250; i++) begin
      steady = (i >= 90 && i < 160);
      r = $urandom_range(99);
      if (r < 35)      op = OpInsert;
      else if (r < 70) op = OpLookup;
      else if (r < 76) op = OpStart;
      else             op = OpNext;
      k = (op == OpInsert || op == OpLookup) ? pick_key() : rand_key();
      issue(op, k, $urandom());
    end
    steady = 1'b0;

    // Duplicate insert, lookup of the newest key, then walk the table
    issue(OpInsert, used_keys[0], $urandom());
    issue(OpLookup, used_keys[$], '0);
    full_walk(130);

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else                 $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
